### sv/rrc_pkg.sv
// ----------------------------------------------------------------------------
// Reflectivity to rain rate: shared package
// Register indexes, reset values, fixed-point constants, the item types that
// pass between the pipeline sections, and the roots used by the exp2 steps.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned EXP_STAGES = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DBZ_GAIN       = 3'd0,
    REG_DBZ_OFFSET     = 3'd1,
    REG_LOW_THRESHOLD  = 3'd2,
    REG_HAIL_THRESHOLD = 3'd3,
    REG_COEFF_LOG2     = 3'd4,
    REG_EXPON_RECIP    = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] GAIN_RESET   = 16'd2048;
  localparam logic [15:0] OFFSET_RESET = 16'hE000;
  localparam logic [15:0] LOW_RESET    = 16'd0;
  localparam logic [15:0] HAIL_RESET   = 16'd14080;
  localparam logic [23:0] COEFF_RESET  = 24'd500951;
  localparam logic [17:0] RECIP_RESET  = 18'd40960;

  // log2(10)/10 in Q0.32.
  localparam logic [31:0] LOG2_TEN_TENTH = 32'd1426757253;
  // -100 dBZ in Q.12.
  localparam logic signed [24:0] FORCED_DBZ_Q12 = -25'sd409600;
  localparam logic [31:0] MIN_RATE_Q16 = 32'd66;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef struct packed {
    logic [15:0] dbz_gain;
    logic [15:0] dbz_offset;
    logic [15:0] low_threshold;
    logic [15:0] hail_threshold;
    logic [23:0] coeff_log2;
    logic [17:0] expon_recip;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] n;
    logic [15:0]        f;
    logic [31:0]        m;
  } exp_item_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] r;
    logic [63:0] b;
    rem = v;
    r   = 64'd0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q.30 value of 2^(2^-k), built by repeated square roots.
  function automatic logic [31:0] exp2_root(input int unsigned k);
    logic [63:0] root;
    root = 64'd1 << 31;
    for (int unsigned i = 1; i <= EXP_STAGES; i++) begin
      if (i <= k) begin
        root = isqrt64(root << 30);
      end
    end
    return root[31:0];
  endfunction

endpackage

### sv/rrc_front.sv
// ----------------------------------------------------------------------------
// Reflectivity to rain rate: front section
// Six stages: code to dBZ, threshold and hail clamp, scaling to log2, removal
// of log2 a, scaling by 1/b and rounding into integer and fraction parts.
// ----------------------------------------------------------------------------
module rrc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  rrc_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          code,
  output logic                out_valid,
  input  logic                out_ready,
  output rrc_pkg::exp_item_t  out_item
);

  localparam int unsigned STAGES = 6;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] en;

  logic signed [24:0] dbz0_r, dbz0_nxt;
  logic signed [19:0] dbz1_r, dbz1_nxt;
  logic signed [51:0] prod2_r, prod2_nxt;
  logic signed [25:0] t3_r, t3_nxt;
  logic signed [43:0] prod4_r, prod4_nxt;
  logic signed [11:0] n5_r, n5_nxt;
  logic [15:0]        f5_r, f5_nxt;

  logic signed [24:0] code_s, gain_s, off_s, low_s, hail_s, lim;
  logic signed [51:0] rnd3;
  logic signed [43:0] rnd5;

  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_comb begin
    code_s   = $signed({17'd0, code});
    gain_s   = $signed({{9{cfg.dbz_gain[15]}}, cfg.dbz_gain});
    off_s    = $signed({{5{cfg.dbz_offset[15]}}, cfg.dbz_offset, 4'd0});
    dbz0_nxt = code_s * gain_s + off_s;
  end

  always_comb begin
    low_s  = $signed({{5{cfg.low_threshold[15]}}, cfg.low_threshold, 4'd0});
    hail_s = $signed({{5{cfg.hail_threshold[15]}}, cfg.hail_threshold, 4'd0});
    lim    = (dbz0_r < low_s) ? rrc_pkg::FORCED_DBZ_Q12 : dbz0_r;
    if (lim > hail_s) begin
      lim = hail_s;
    end
    dbz1_nxt = $signed(lim[19:0]);
  end

  assign prod2_nxt = 52'(dbz1_r) * $signed({20'd0, rrc_pkg::LOG2_TEN_TENTH});

  always_comb begin
    rnd3   = prod2_r + 52'sd134217728;
    t3_nxt = 26'($signed(rnd3[51:28])) - $signed({2'b00, cfg.coeff_log2});
  end

  assign prod4_nxt = 44'(t3_r) * $signed({26'd0, cfg.expon_recip});

  always_comb begin
    rnd5   = prod4_r + 44'sd32768;
    n5_nxt = $signed(rnd5[43:32]);
    f5_nxt = rnd5[31:16];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dbz0_r <= dbz0_nxt;
    end
    if (en[1]) begin
      dbz1_r <= dbz1_nxt;
    end
    if (en[2]) begin
      prod2_r <= prod2_nxt;
    end
    if (en[3]) begin
      t3_r <= t3_nxt;
    end
    if (en[4]) begin
      prod4_r <= prod4_nxt;
    end
    if (en[5]) begin
      n5_r <= n5_nxt;
      f5_r <= f5_nxt;
    end
  end

  always_comb begin
    out_item.n = n5_r;
    out_item.f = f5_r;
    out_item.m = rrc_pkg::ONE_Q30;
  end

endmodule

### sv/rrc_exp2_stage.sv
// ----------------------------------------------------------------------------
// Reflectivity to rain rate: one exp2 step
// Multiplies the mantissa by 2^(2^-k) with rounding when fraction bit 16-k is
// set, and holds the result in a pipeline register.
// ----------------------------------------------------------------------------
module rrc_exp2_stage #(
  parameter int unsigned STAGE_K = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrc_pkg::exp_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rrc_pkg::exp_item_t  out_item
);

  localparam logic [31:0] ROOT    = rrc_pkg::exp2_root(STAGE_K);
  localparam int unsigned BIT_POS = rrc_pkg::FRAC_BITS - STAGE_K;

  logic               v_r;
  rrc_pkg::exp_item_t item_r, item_nxt;
  logic [63:0]        prod;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_item  = item_r;

  always_comb begin
    prod     = {32'd0, in_item.m} * {32'd0, ROOT} + (64'd1 << 29);
    item_nxt = in_item;
    if (in_item.f[BIT_POS]) begin
      item_nxt.m = prod[61:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

### sv/rrc_back.sv
// ----------------------------------------------------------------------------
// Reflectivity to rain rate: back section
// Scales the Q.30 mantissa by the integer exponent with rounding and
// saturation, then zeroes rates below 0.001 mm/h in the output register.
// ----------------------------------------------------------------------------
module rrc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rrc_pkg::exp_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         rain_rate,
  output logic                saturated
);

  logic [1:0]  v_r;
  logic [1:0]  en;
  logic [31:0] rate_a_r, rate_a_nxt;
  logic        sat_a_r, sat_a_nxt;
  logic [31:0] rate_b_r, rate_b_nxt;
  logic        sat_b_r;
  logic [32:0] wide;
  logic [32:0] sum;
  logic [12:0] shr;
  logic [4:0]  sh;

  always_comb begin
    en[1] = !v_r[1] || out_ready;
    en[0] = !v_r[0] || en[1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[1];
  assign rain_rate = rate_b_r;
  assign saturated = sat_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      if (en[1]) begin
        v_r[1] <= v_r[0];
      end
    end
  end

  always_comb begin
    shr        = 13'sd14 - 13'(in_item.n);
    sh         = shr[4:0];
    wide       = {1'b0, in_item.m} << ((in_item.n == 12'sd15) ? 1 : 0);
    sum        = ({1'b0, in_item.m} + (33'd1 << (5'(sh - 5'd1)))) >> sh;
    sat_a_nxt  = 1'b0;
    rate_a_nxt = 32'd0;
    if (in_item.n >= 12'sd16) begin
      sat_a_nxt  = 1'b1;
      rate_a_nxt = '1;
    end else if (in_item.n >= 12'sd14) begin
      if (wide[32]) begin
        sat_a_nxt  = 1'b1;
        rate_a_nxt = '1;
      end else begin
        rate_a_nxt = wide[31:0];
      end
    end else if (shr < 13'd32) begin
      rate_a_nxt = sum[31:0];
    end
  end

  assign rate_b_nxt = (!sat_a_r && (rate_a_r < rrc_pkg::MIN_RATE_Q16)) ? 32'd0 : rate_a_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rate_a_r <= rate_a_nxt;
      sat_a_r  <= sat_a_nxt;
    end
    if (en[1]) begin
      rate_b_r <= rate_b_nxt;
      sat_b_r  <= sat_a_r;
    end
  end

endmodule

### sv/reflectivity_to_rain_rate_core.sv
// ----------------------------------------------------------------------------
// Reflectivity to rain rate: top level
// Turns 8-bit reflectivity codes into Z-R power-law rain rates, Q16.16.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  in_      slave      tdata[7:0] dbz_code
//  out_     master     tdata[31:0] rain_rate, tuser[0] saturated
//  cfg_     write      addr[2:0] register index, wdata[23:0] value
//
// One item can enter every cycle while the output does not stall, and passes through six
// front stages, sixteen exp2 multiply stages and two output stages.
// Reset is synchronous; it clears the valid bits and loads the configuration reset values.
// A full stage holds only while its successor holds, so bubbles close up and a
// stall on the output loses and repeats nothing.
module reflectivity_to_rain_rate_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] dbz_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] rain_rate
  output logic        out_tuser,  // [0] saturated
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  localparam int unsigned NSTG = rrc_pkg::EXP_STAGES;

  rrc_pkg::cfg_t      cfg_r;
  logic [NSTG:0]      ev;
  logic [NSTG:0]      er;
  rrc_pkg::exp_item_t ei [NSTG+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dbz_gain       <= rrc_pkg::GAIN_RESET;
      cfg_r.dbz_offset     <= rrc_pkg::OFFSET_RESET;
      cfg_r.low_threshold  <= rrc_pkg::LOW_RESET;
      cfg_r.hail_threshold <= rrc_pkg::HAIL_RESET;
      cfg_r.coeff_log2     <= rrc_pkg::COEFF_RESET;
      cfg_r.expon_recip    <= rrc_pkg::RECIP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        rrc_pkg::REG_DBZ_GAIN:       cfg_r.dbz_gain       <= cfg_wdata[15:0];
        rrc_pkg::REG_DBZ_OFFSET:     cfg_r.dbz_offset     <= cfg_wdata[15:0];
        rrc_pkg::REG_LOW_THRESHOLD:  cfg_r.low_threshold  <= cfg_wdata[15:0];
        rrc_pkg::REG_HAIL_THRESHOLD: cfg_r.hail_threshold <= cfg_wdata[15:0];
        rrc_pkg::REG_COEFF_LOG2:     cfg_r.coeff_log2     <= cfg_wdata;
        rrc_pkg::REG_EXPON_RECIP:    cfg_r.expon_recip    <= cfg_wdata[17:0];
        default: begin
        end
      endcase
    end
  end

  rrc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .code      (in_tdata),
    .out_valid (ev[0]),
    .out_ready (er[0]),
    .out_item  (ei[0])
  );

  for (genvar k = 1; k <= NSTG; k++) begin : g_exp
    rrc_exp2_stage #(
      .STAGE_K (k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ev[k-1]),
      .in_ready  (er[k-1]),
      .in_item   (ei[k-1]),
      .out_valid (ev[k]),
      .out_ready (er[k]),
      .out_item  (ei[k])
    );
  end

  rrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ev[NSTG]),
    .in_ready  (er[NSTG]),
    .in_item   (ei[NSTG]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .rain_rate (out_tdata),
    .saturated (out_tuser)
  );

  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'hFFFF_FFFF)
    else $error("saturated result is not full scale");

  a_min_rate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0 || out_tdata >= rrc_pkg::MIN_RATE_Q16)
    else $error("rate below the minimum was not zeroed");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output stage is empty");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid directly after reset");

endmodule

### sim/rain_rate_checker.sv
// ----------------------------------------------------------------------------
// Reflectivity to rain rate: result checker
// Follows the register writes and both streams. Every accepted code is turned
// into an expected rain rate and saturation flag. Each result is compared with
// the oldest expectation, and the failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module rain_rate_checker
  import rrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  output int          fail_count,
  output int          due_count,
  output int          rates_checked
);

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] rain_rate;
    logic        saturated;
  } rate_due_t;

  cfg_t        setting;
  rate_due_t   rates_due[$];
  rate_due_t   want;
  logic [63:0] root_q30 [1:FRAC_BITS];
  int          errs;
  int          checked;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] cand;
    r = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= v) begin
        r = cand;
      end
    end
    return r;
  endfunction

  // Q.30 values of 2^(2^-k): each is the square root of the one before.
  initial begin
    logic [63:0] acc;
    acc = 64'd1 << 31;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      acc = floor_sqrt(acc << 30);
      root_q30[k] = acc;
    end
  end

  function automatic rate_due_t rain_rate_of(input logic [7:0] code, input cfg_t s);
    longint      dbz;
    longint      low_q12;
    longint      hail_q12;
    longint      dl;
    longint      t;
    longint      y;
    longint      n;
    longint      shift;
    logic [15:0] f;
    logic [63:0] m;
    logic [63:0] rate;
    rate_due_t   r;
    dbz      = longint'(code) * longint'($signed(s.dbz_gain))
             + longint'($signed(s.dbz_offset)) * 16;
    low_q12  = longint'($signed(s.low_threshold)) * 16;
    hail_q12 = longint'($signed(s.hail_threshold)) * 16;
    if (dbz < low_q12) begin
      dbz = longint'(FORCED_DBZ_Q12);
    end
    if (dbz > hail_q12) begin
      dbz = hail_q12;
    end
    dl = (dbz * longint'(LOG2_TEN_TENTH) + (64'sd1 <<< 27)) >>> 28;
    t  = dl - longint'(s.coeff_log2);
    y  = (t * longint'(s.expon_recip) + 64'sd32768) >>> 16;
    n  = y >>> 16;
    f  = y[15:0];
    m  = 64'd1 << 30;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      if (f[FRAC_BITS - k]) begin
        m = (m * root_q30[k] + (64'd1 << 29)) >> 30;
      end
    end
    r.code      = code;
    r.saturated = 1'b0;
    if (n >= 16) begin
      r.saturated = 1'b1;
      rate = 64'hFFFF_FFFF;
    end else if (n >= 14) begin
      rate = m << (n - 14);
      if (rate > 64'hFFFF_FFFF) begin
        r.saturated = 1'b1;
        rate = 64'hFFFF_FFFF;
      end
    end else begin
      shift = 14 - n;
      if (shift >= 32) begin
        rate = 64'd0;
      end else begin
        rate = (m + (64'd1 << (shift - 1))) >> shift;
      end
    end
    if (!r.saturated && rate < 64'(MIN_RATE_Q16)) begin
      rate = 64'd0;
    end
    r.rain_rate = rate[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      setting.dbz_gain       <= GAIN_RESET;
      setting.dbz_offset     <= OFFSET_RESET;
      setting.low_threshold  <= LOW_RESET;
      setting.hail_threshold <= HAIL_RESET;
      setting.coeff_log2     <= COEFF_RESET;
      setting.expon_recip    <= RECIP_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DBZ_GAIN:       setting.dbz_gain       <= cfg_wdata[15:0];
        REG_DBZ_OFFSET:     setting.dbz_offset     <= cfg_wdata[15:0];
        REG_LOW_THRESHOLD:  setting.low_threshold  <= cfg_wdata[15:0];
        REG_HAIL_THRESHOLD: setting.hail_threshold <= cfg_wdata[15:0];
        REG_COEFF_LOG2:     setting.coeff_log2     <= cfg_wdata[23:0];
        REG_EXPON_RECIP:    setting.expon_recip    <= cfg_wdata[17:0];
        default: ;
      endcase
    end
  end

  initial begin
    errs    = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (rates_due.size() == 0) begin
          $display("%0t: unexpected rain rate %h saturated %b with no code outstanding",
                   $time, out_tdata, out_tuser);
          errs++;
        end else begin
          want = rates_due.pop_front();
          if (out_tdata !== want.rain_rate) begin
            $display("%0t: code %h rain rate expected %h, got %h",
                     $time, want.code, want.rain_rate, out_tdata);
            errs++;
          end
          if (out_tuser !== want.saturated) begin
            $display("%0t: code %h saturated flag expected %b, got %b",
                     $time, want.code, want.saturated, out_tuser);
            errs++;
          end
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        rates_due.push_back(rain_rate_of(in_tdata, setting));
      end
    end
    due_count     <= rates_due.size();
    fail_count    <= errs;
    rates_checked <= checked;
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// Reflectivity to rain rate: testbench top
// Drives reflectivity codes and register settings into the core and gives the
// verdict. A directed set covers the threshold edges, saturation, vanishing
// rates and a zero exponent reciprocal; random codes then run under many
// register settings and several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import rrc_pkg::*;

  localparam int          RESET_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          QUIET_LIMIT  = 5000;
  localparam int          TAIL_CYCLES  = 40;
  localparam int          SEGMENTS     = 4;
  localparam int          SEGMENT_LEN  = 28;
  localparam logic [2:0]  SPARE_INDEX_LO = 3'd6;
  localparam logic [2:0]  SPARE_INDEX_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] dbz_code
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // [31:0] rain_rate
  logic        out_tuser;   // [0] saturated
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  int          fail_count;
  int          due_count;
  int          rates_checked;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int          codes_sent = 0;
  int          settings_used = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;

  always #5 clk = ~clk;

  reflectivity_to_rain_rate_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  rain_rate_checker u_rate_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .due_count     (due_count),
    .rates_checked (rates_checked)
  );

  task automatic send_code(input logic [7:0] code);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    codes_sent++;
  endtask

  // The extra edge lets the checker count an item taken at the last edge.
  task automatic end_burst();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Unused upper bits of the write data carry junk, which the core must ignore.
  task automatic write_setting(input cfg_t s);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_DBZ_GAIN,       {junk[7:0], s.dbz_gain});
    write_reg(REG_DBZ_OFFSET,     {junk[15:8], s.dbz_offset});
    write_reg(REG_LOW_THRESHOLD,  {junk[23:16], s.low_threshold});
    write_reg(REG_HAIL_THRESHOLD, {junk[31:24], s.hail_threshold});
    write_reg(REG_COEFF_LOG2,     s.coeff_log2);
    write_reg(REG_EXPON_RECIP,    {junk[5:0], s.expon_recip});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t reset_setting();
    cfg_t s;
    s.dbz_gain       = GAIN_RESET;
    s.dbz_offset     = OFFSET_RESET;
    s.low_threshold  = LOW_RESET;
    s.hail_threshold = HAIL_RESET;
    s.coeff_log2     = COEFF_RESET;
    s.expon_recip    = RECIP_RESET;
    return s;
  endfunction

  // Mostly plausible radar settings, so that the rates land in range; the
  // rest draw every register over its whole width.
  function automatic cfg_t random_setting();
    cfg_t s;
    if ($urandom_range(0, 3) != 0) begin
      s.dbz_gain       = 16'($urandom_range(1024, 4096));
      s.dbz_offset     = 16'(0 - $urandom_range(0, 16384));
      s.low_threshold  = 16'($urandom_range(0, 10240) - 5120);
      s.hail_threshold = 16'($urandom_range(10240, 17920));
      s.coeff_log2     = 24'($urandom_range(360000, 600000));
      s.expon_recip    = 18'($urandom_range(30000, 60000));
    end else begin
      s.dbz_gain       = 16'($urandom);
      s.dbz_offset     = 16'($urandom);
      s.low_threshold  = 16'($urandom);
      s.hail_threshold = 16'($urandom);
      s.coeff_log2     = 24'($urandom);
      s.expon_recip    = 18'($urandom);
    end
    return s;
  endfunction

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // The longest quiet stretch of a correct run is the long output hold.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("reflectivity_to_rain_rate_core test failed");
    $finish;
  end

  initial begin
    cfg_t        s;
    logic [7:0]  start_codes [12];
    int unsigned idle_mix [4][2];
    start_codes = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd100,
                    8'd174, 8'd175, 8'd200, 8'h55, 8'hAA, 8'd255};
    idle_mix    = '{'{0, 0}, '{61, 0}, '{0, 61}, '{23, 23}};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'd0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_DBZ_GAIN;
    cfg_wdata <= 24'd0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: codes either side of the no-rain and hail limits.
    foreach (start_codes[i]) begin
      send_code(start_codes[i]);
    end
    end_burst();

    // Faint echo let through: the rate falls under the reporting floor.
    s = reset_setting();
    s.low_threshold = 16'h8000;
    write_setting(s);
    send_code(8'd0);
    send_code(8'd20);
    end_burst();

    // Largest gain, ceiling and exponent: the rate saturates quickly.
    s = '{dbz_gain: 16'h7FFF, dbz_offset: 16'h0000, low_threshold: 16'h8000,
          hail_threshold: 16'h7FFF, coeff_log2: 24'h000000, expon_recip: 18'h3FFFF};
    write_setting(s);
    send_code(8'd0);
    send_code(8'd1);
    send_code(8'd2);
    send_code(8'd3);
    send_code(8'd255);
    end_burst();

    // Minimum gain, offset, limits; maximum a, 1/b: the exponent is far below range.
    s = '{dbz_gain: 16'h8000, dbz_offset: 16'h8000, low_threshold: 16'h8000,
          hail_threshold: 16'h8000, coeff_log2: 24'hFFFFFF, expon_recip: 18'h3FFFF};
    write_setting(s);
    send_code(8'd0);
    send_code(8'd128);
    send_code(8'd255);
    end_burst();

    // A zero exponent reciprocal gives a rate of one; spare indexes change nothing.
    s = reset_setting();
    s.expon_recip = 18'd0;
    write_setting(s);
    @(posedge clk);
    write_reg(SPARE_INDEX_LO, 24'hFFFFFF);
    write_reg(SPARE_INDEX_HI, 24'h000000);
    cfg_we <= 1'b0;
    send_code(8'd0);
    send_code(8'd255);
    end_burst();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_mix[phase][0];
      stall_pct = idle_mix[phase][1];
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        write_setting(random_setting());
        if (phase == 0 && seg == 0) begin
          hold_req = 1'b1;
          repeat (60) send_code(8'($urandom));
          end_burst();
        end
        repeat (SEGMENT_LEN) send_code(8'($urandom));
        end_burst();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d reflectivity codes under %0d register settings; %0d rates checked.",
             codes_sent, settings_used, rates_checked);
    $display("Sender gaps and receiver stalls were mixed, with one long output hold.");
    if (fail_count == 0) begin
      $display("reflectivity_to_rain_rate_core test passed");
    end else begin
      $display("reflectivity_to_rain_rate_core test failed");
    end
    $finish;
  end

endmodule
